@@ rtl/core/olist_pkg.sv @@
// shared types and constants of the ordered list block
`timescale 1ns / 1ps

package olist_pkg;

   localparam int CMD_W        = 3;
   localparam int POS_W        = 7;
   localparam int VALUE_PORT_W = 32;
   localparam int FOUND_W      = 6;
   localparam int TOTAL_W      = 7;
   localparam int STATUS_W     = 2;

   localparam logic [CMD_W-1:0] CMD_APPEND     = 3'd0;
   localparam logic [CMD_W-1:0] CMD_INSERT     = 3'd1;
   localparam logic [CMD_W-1:0] CMD_REMOVE     = 3'd2;
   localparam logic [CMD_W-1:0] CMD_REMOVE_ALL = 3'd3;
   localparam logic [CMD_W-1:0] CMD_FIND       = 3'd4;
   localparam logic [CMD_W-1:0] CMD_READ       = 3'd5;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

   typedef enum logic [2:0] {
      OP_HOLD,
      OP_INSERT,
      OP_REMOVE,
      OP_MARK,
      OP_SORT
   } op_type;

   typedef struct packed {
      op_type op;
      logic   parity;
   } ctl_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_SCAN,
      S_SORT
   } state_type;

endpackage

@@ rtl/core/olist_cell.sv @@
// one cell of the list chain: an entry, its hole flag and a stage of the search token
`timescale 1ns / 1ps

module olist_cell
   import olist_pkg::*;
#(
   parameter int  CAPACITY    = 64,
   parameter int  VALUE_WIDTH = 32,
   parameter int  INDEX       = 0,
   localparam int SW          = (VALUE_WIDTH < VALUE_PORT_W) ? VALUE_WIDTH : VALUE_PORT_W,
   localparam int IW          = $clog2(CAPACITY),
   localparam int CW          = $clog2(CAPACITY + 1),
   localparam int CMPW        = (CW > POS_W) ? CW : POS_W
) (
   input  logic                 clock,
   input  logic                 reset,
   input  ctl_type              ctl,
   input  logic [CMPW-1:0]      pos,
   input  logic [CW-1:0]        fill,
   input  logic [SW-1:0]        word,
   input  logic [SW-1:0]        lo_data,
   input  logic                 lo_hole,
   input  logic [SW-1:0]        hi_data,
   input  logic                 hi_hole,
   input  logic                 tok_in_valid,
   input  logic                 tok_in_found,
   input  logic [IW-1:0]        tok_in_idx,
   input  logic [CW-1:0]        tok_in_hits,
   input  logic [SW-1:0]        tok_in_data,
   output logic [SW-1:0]        data,
   output logic                 hole,
   output logic                 tok_valid,
   output logic                 tok_found,
   output logic [IW-1:0]        tok_idx,
   output logic [CW-1:0]        tok_hits,
   output logic [SW-1:0]        tok_data
);

   localparam logic [CMPW-1:0] MY_INDEX = CMPW'(INDEX);
   localparam logic            HAS_LO   = (INDEX > 0);
   localparam logic            HAS_HI   = (INDEX < CAPACITY - 1);
   localparam logic            ODD      = 1'(INDEX % 2);

   logic [SW-1:0] data_ff, data_in;
   logic          hole_ff, hole_in;
   logic          tok_valid_ff, tok_valid_in;
   logic          tok_found_ff, tok_found_in;
   logic [IW-1:0] tok_idx_ff, tok_idx_in;
   logic [CW-1:0] tok_hits_ff, tok_hits_in;
   logic [SW-1:0] tok_data_ff, tok_data_in;

   logic in_use;
   logic hit;
   logic pair_hi;

   assign in_use  = MY_INDEX < CMPW'(fill);
   assign hit     = data_ff == word;
   assign pair_hi = ctl.parity == ODD;

   always_comb begin
      data_in = data_ff;
      hole_in = hole_ff;
      unique case (ctl.op)
         OP_HOLD: begin
         end
         OP_INSERT: begin
            if (MY_INDEX > pos) begin
               data_in = lo_data;
            end else if (MY_INDEX == pos) begin
               data_in = word;
            end
         end
         OP_REMOVE: begin
            if (HAS_HI && (MY_INDEX >= pos)) begin
               data_in = hi_data;
            end
         end
         OP_MARK: begin
            hole_in = !in_use || hit;
         end
         OP_SORT: begin
            // odd-even exchange of a hole with the word above it
            if (pair_hi) begin
               if (HAS_HI && hole_ff && !hi_hole) begin
                  data_in = hi_data;
                  hole_in = hi_hole;
               end
            end else if (HAS_LO && lo_hole && !hole_ff) begin
               data_in = lo_data;
               hole_in = lo_hole;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      tok_valid_in = tok_in_valid;
      tok_found_in = tok_in_found;
      tok_idx_in   = tok_in_idx;
      tok_hits_in  = tok_in_hits;
      tok_data_in  = tok_in_data;
      if (tok_in_valid) begin
         if (in_use && hit) begin
            tok_hits_in = tok_in_hits + CW'(1);
            if (!tok_in_found) begin
               tok_found_in = 1'b1;
               tok_idx_in   = IW'(INDEX);
            end
         end
         if (MY_INDEX == pos) begin
            tok_data_in = data_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      data_ff     <= data_in;
      hole_ff     <= hole_in;
      tok_found_ff <= tok_found_in;
      tok_idx_ff  <= tok_idx_in;
      tok_hits_ff <= tok_hits_in;
      tok_data_ff <= tok_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_valid_ff <= 1'b0;
      end else begin
         tok_valid_ff <= tok_valid_in;
      end
   end

   assign data      = data_ff;
   assign hole      = hole_ff;
   assign tok_valid = tok_valid_ff;
   assign tok_found = tok_found_ff;
   assign tok_idx   = tok_idx_ff;
   assign tok_hits  = tok_hits_ff;
   assign tok_data  = tok_data_ff;

endmodule

@@ rtl/core/olist_ctrl.sv @@
// command sequencer of the list: range checks, count, cell broadcast and result register
`timescale 1ns / 1ps

module olist_ctrl
   import olist_pkg::*;
#(
   parameter int  CAPACITY    = 64,
   parameter int  VALUE_WIDTH = 32,
   localparam int SW          = (VALUE_WIDTH < VALUE_PORT_W) ? VALUE_WIDTH : VALUE_PORT_W,
   localparam int IW          = $clog2(CAPACITY),
   localparam int CW          = $clog2(CAPACITY + 1),
   localparam int CMPW        = (CW > POS_W) ? CW : POS_W
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic [CMD_W-1:0]        req_cmd,
   input  logic [POS_W-1:0]        req_position,
   input  logic [VALUE_PORT_W-1:0] req_value,
   output logic                    rsp_valid,
   output logic [VALUE_PORT_W-1:0] rsp_read_value,
   output logic [FOUND_W-1:0]      rsp_found_index,
   output logic                    rsp_found,
   output logic [TOTAL_W-1:0]      rsp_entry_total,
   output logic [STATUS_W-1:0]     rsp_status,
   output ctl_type                 cell_ctl,
   output logic [CMPW-1:0]         cell_pos,
   output logic [CW-1:0]           cell_fill,
   output logic [SW-1:0]           cell_word,
   output logic                    tok_launch,
   input  logic                    last_tok_valid,
   input  logic                    last_tok_found,
   input  logic [IW-1:0]           last_tok_idx,
   input  logic [CW-1:0]           last_tok_hits,
   input  logic [SW-1:0]           last_tok_data
);

   state_type             state_ff, state_in;
   logic [CMD_W-1:0]      cmd_ff, cmd_in;
   logic [POS_W-1:0]      pos_ff, pos_in;
   logic [SW-1:0]         word_ff, word_in;
   logic [CW-1:0]         fill_ff, fill_in;
   logic [IW-1:0]         cnt_ff, cnt_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [VALUE_PORT_W-1:0] rsp_read_value_ff, rsp_read_value_in;
   logic [FOUND_W-1:0]      rsp_found_index_ff, rsp_found_index_in;
   logic                    rsp_found_ff, rsp_found_in;
   logic [TOTAL_W-1:0]      rsp_entry_total_ff, rsp_entry_total_in;
   logic [STATUS_W-1:0]     rsp_status_ff, rsp_status_in;

   logic [CMPW-1:0] pos_ext;
   logic [CMPW-1:0] fill_ext;
   logic            full;

   assign pos_ext  = CMPW'(pos_ff);
   assign fill_ext = CMPW'(fill_ff);
   assign full     = fill_ff == CW'(CAPACITY);
   assign busy     = state_ff != S_IDLE;

   always_comb begin
      state_in           = state_ff;
      cmd_in             = cmd_ff;
      pos_in             = pos_ff;
      word_in            = word_ff;
      fill_in            = fill_ff;
      cnt_in             = cnt_ff;
      rsp_valid_in       = 1'b0;
      rsp_read_value_in  = '0;
      rsp_found_index_in = '0;
      rsp_found_in       = 1'b0;
      rsp_status_in      = ST_OK;
      cell_ctl.op        = OP_HOLD;
      cell_ctl.parity    = cnt_ff[0];
      tok_launch         = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd_in   = req_cmd;
               pos_in   = req_position;
               word_in  = SW'(req_value);
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in     = S_IDLE;
            rsp_valid_in = 1'b1;
            unique case (cmd_ff)
               CMD_APPEND: begin
                  if (full) begin
                     rsp_status_in = ST_FULL;
                  end else begin
                     cell_ctl.op = OP_INSERT;
                     fill_in     = fill_ff + CW'(1);
                  end
               end
               CMD_INSERT: begin
                  if (pos_ext > fill_ext) begin
                     rsp_status_in = ST_RANGE;
                  end else if (full) begin
                     rsp_status_in = ST_FULL;
                  end else begin
                     cell_ctl.op = OP_INSERT;
                     fill_in     = fill_ff + CW'(1);
                  end
               end
               CMD_REMOVE: begin
                  if (pos_ext >= fill_ext) begin
                     rsp_status_in = ST_RANGE;
                  end else begin
                     cell_ctl.op = OP_REMOVE;
                     fill_in     = fill_ff - CW'(1);
                  end
               end
               CMD_REMOVE_ALL, CMD_FIND: begin
                  tok_launch   = 1'b1;
                  rsp_valid_in = 1'b0;
                  state_in     = S_SCAN;
               end
               CMD_READ: begin
                  if (pos_ext >= fill_ext) begin
                     rsp_status_in = ST_RANGE;
                  end else begin
                     tok_launch   = 1'b1;
                     rsp_valid_in = 1'b0;
                     state_in     = S_SCAN;
                  end
               end
               default: begin
               end
            endcase
         end
         S_SCAN: begin
            if (last_tok_valid) begin
               priority if (cmd_ff == CMD_REMOVE_ALL) begin
                  cell_ctl.op = OP_MARK;
                  fill_in     = fill_ff - last_tok_hits;
                  cnt_in      = '0;
                  state_in    = S_SORT;
               end else if (cmd_ff == CMD_FIND) begin
                  rsp_valid_in       = 1'b1;
                  rsp_found_in       = last_tok_found;
                  rsp_found_index_in = last_tok_found ? FOUND_W'(last_tok_idx) : '0;
                  state_in           = S_IDLE;
               end else begin
                  rsp_valid_in      = 1'b1;
                  rsp_read_value_in = VALUE_PORT_W'(last_tok_data);
                  state_in          = S_IDLE;
               end
            end
         end
         S_SORT: begin
            cell_ctl.op = OP_SORT;
            cnt_in      = cnt_ff + IW'(1);
            if (cnt_ff == IW'(CAPACITY - 1)) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      rsp_entry_total_in = TOTAL_W'(fill_in);
   end

   assign cell_pos  = (cmd_ff == CMD_APPEND) ? fill_ext : pos_ext;
   assign cell_fill = fill_ff;
   assign cell_word = word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff             <= cmd_in;
      pos_ff             <= pos_in;
      word_ff            <= word_in;
      cnt_ff             <= cnt_in;
      rsp_read_value_ff  <= rsp_read_value_in;
      rsp_found_index_ff <= rsp_found_index_in;
      rsp_found_ff       <= rsp_found_in;
      rsp_entry_total_ff <= rsp_entry_total_in;
      rsp_status_ff      <= rsp_status_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_value  = rsp_read_value_ff;
   assign rsp_found_index = rsp_found_index_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_entry_total = rsp_entry_total_ff;
   assign rsp_status      = rsp_status_ff;

`ifndef SYNTHESIS
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CW'(CAPACITY))
      else $error("entry count above capacity");

   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (state_ff == S_EXEC))
      else $error("accepted word not executed");

   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(busy) && !busy))
      else $error("result strobe outside command end");

   a_token_in_scan: assert property (@(posedge clock) disable iff (reset)
      last_tok_valid |-> (state_ff == S_SCAN))
      else $error("search token left chain outside scan");

   a_no_launch_twice: assert property (@(posedge clock) disable iff (reset)
      tok_launch |=> !tok_launch)
      else $error("token launched on consecutive cycles");
`endif

endmodule

@@ rtl/core/ordered_list_insert_remove_find_top.sv @@
// top level of the ordered list: sequencer and the chain of entry cells
`timescale 1ns / 1ps

// Ordered list of up to CAPACITY words held in a chain of cells, one entry per cell.
// A command word is taken when start is high and busy is low; its result shows on the
// rsp_ ports for one cycle with rsp_valid and must be taken then, as the block cannot be
// held off. Append, insert, remove at position, out-of-range commands and unknown codes
// are done in the execute state after the word is registered; insert and remove shift
// the cells at and above the position by one place. Find and read launch a search token
// that ripples one cell per cycle from the first cell to the last. Remove-all uses the
// token pass to count matches, marks matches and unused cells as holes, then odd-even
// exchange rounds close the gaps while keeping order. No clearing pass after reset.

module ordered_list_insert_remove_find_top
   import olist_pkg::*;
#(
   parameter int CAPACITY    = 64,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic [CMD_W-1:0]        req_cmd,
   input  logic [POS_W-1:0]        req_position,
   input  logic [VALUE_PORT_W-1:0] req_value,
   output logic                    rsp_valid,
   output logic [VALUE_PORT_W-1:0] rsp_read_value,
   output logic [FOUND_W-1:0]      rsp_found_index,
   output logic                    rsp_found,
   output logic [TOTAL_W-1:0]      rsp_entry_total,
   output logic [STATUS_W-1:0]     rsp_status
);

   localparam int SW   = (VALUE_WIDTH < VALUE_PORT_W) ? VALUE_WIDTH : VALUE_PORT_W;
   localparam int IW   = $clog2(CAPACITY);
   localparam int CW   = $clog2(CAPACITY + 1);
   localparam int CMPW = (CW > POS_W) ? CW : POS_W;

   ctl_type         cell_ctl;
   logic [CMPW-1:0] cell_pos;
   logic [CW-1:0]   cell_fill;
   logic [SW-1:0]   cell_word;
   logic            tok_launch;

   logic [SW-1:0] data_w      [CAPACITY];
   logic          hole_w      [CAPACITY];
   logic          tok_valid_w [CAPACITY];
   logic          tok_found_w [CAPACITY];
   logic [IW-1:0] tok_idx_w   [CAPACITY];
   logic [CW-1:0] tok_hits_w  [CAPACITY];
   logic [SW-1:0] tok_data_w  [CAPACITY];

   olist_ctrl #(
      .CAPACITY    (CAPACITY),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_cmd         (req_cmd),
      .req_position    (req_position),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_read_value  (rsp_read_value),
      .rsp_found_index (rsp_found_index),
      .rsp_found       (rsp_found),
      .rsp_entry_total (rsp_entry_total),
      .rsp_status      (rsp_status),
      .cell_ctl        (cell_ctl),
      .cell_pos        (cell_pos),
      .cell_fill       (cell_fill),
      .cell_word       (cell_word),
      .tok_launch      (tok_launch),
      .last_tok_valid  (tok_valid_w[CAPACITY-1]),
      .last_tok_found  (tok_found_w[CAPACITY-1]),
      .last_tok_idx    (tok_idx_w[CAPACITY-1]),
      .last_tok_hits   (tok_hits_w[CAPACITY-1]),
      .last_tok_data   (tok_data_w[CAPACITY-1])
   );

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [SW-1:0] lo_data;
      logic          lo_hole;
      logic [SW-1:0] hi_data;
      logic          hi_hole;
      logic          tin_valid;
      logic          tin_found;
      logic [IW-1:0] tin_idx;
      logic [CW-1:0] tin_hits;
      logic [SW-1:0] tin_data;

      if (i == 0) begin : g_first
         assign lo_data   = '0;
         assign lo_hole   = 1'b0;
         assign tin_valid = tok_launch;
         assign tin_found = 1'b0;
         assign tin_idx   = '0;
         assign tin_hits  = '0;
         assign tin_data  = '0;
      end else begin : g_link
         assign lo_data   = data_w[i-1];
         assign lo_hole   = hole_w[i-1];
         assign tin_valid = tok_valid_w[i-1];
         assign tin_found = tok_found_w[i-1];
         assign tin_idx   = tok_idx_w[i-1];
         assign tin_hits  = tok_hits_w[i-1];
         assign tin_data  = tok_data_w[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign hi_data = '0;
         assign hi_hole = 1'b0;
      end else begin : g_up
         assign hi_data = data_w[i+1];
         assign hi_hole = hole_w[i+1];
      end

      olist_cell #(
         .CAPACITY    (CAPACITY),
         .VALUE_WIDTH (VALUE_WIDTH),
         .INDEX       (i)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .ctl          (cell_ctl),
         .pos          (cell_pos),
         .fill         (cell_fill),
         .word         (cell_word),
         .lo_data      (lo_data),
         .lo_hole      (lo_hole),
         .hi_data      (hi_data),
         .hi_hole      (hi_hole),
         .tok_in_valid (tin_valid),
         .tok_in_found (tin_found),
         .tok_in_idx   (tin_idx),
         .tok_in_hits  (tin_hits),
         .tok_in_data  (tin_data),
         .data         (data_w[i]),
         .hole         (hole_w[i]),
         .tok_valid    (tok_valid_w[i]),
         .tok_found    (tok_found_w[i]),
         .tok_idx      (tok_idx_w[i]),
         .tok_hits     (tok_hits_w[i]),
         .tok_data     (tok_data_w[i])
      );
   end

endmodule
